// ===== hdl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and fixed-point helpers for the escape-time core.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  localparam int GRID_WIDTH    = 64;
  localparam int GRID_HEIGHT   = 32;
  localparam int FRACTION_BITS = 14;

  // Q4.F operands, exact double-width products, one guard bit for sums
  localparam int Q_W    = 4 + FRACTION_BITS;
  localparam int PROD_W = 2 * Q_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int COL_W = 6;
  localparam int ROW_W = 5;
  localparam int CNT_W = 8;
  localparam int MAP_W = 12;

  localparam int COL_SH = FRACTION_BITS - $clog2(GRID_WIDTH / 4);
  localparam int ROW_SH = FRACTION_BITS - $clog2(GRID_HEIGHT / 4);
  localparam logic signed [MAP_W-1:0] COL_HALF = MAP_W'(GRID_WIDTH / 2);
  localparam logic signed [MAP_W-1:0] ROW_HALF = MAP_W'(GRID_HEIGHT / 2);

  // APB map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_ITER_LIMIT = 1'b0;
  localparam logic [CNT_W-1:0] ITER_LIMIT_RST = 8'd20;

  localparam logic signed [SUM_W-1:0] Q_MAX_W =
    {{(SUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] Q_MIN_W =
    {{(SUM_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] FOUR_SQ = SUM_W'(4) << (2 * FRACTION_BITS);

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic             done;
    logic             in_set;
    logic [CNT_W-1:0] iters;
  } mbe_res_t;

  function automatic q_t sat_q(input logic signed [SUM_W-1:0] v);
    if (v > Q_MAX_W) begin
      return Q_MAX_W[Q_W-1:0];
    end else if (v < Q_MIN_W) begin
      return Q_MIN_W[Q_W-1:0];
    end
    return v[Q_W-1:0];
  endfunction

  // (idx - half) scaled to Q4.F; quarter is a power of two so this is a shift
  function automatic q_t map_axis(input logic [MAP_W-1:0] idx,
                                  input logic signed [MAP_W-1:0] half,
                                  input int shamt);
    logic signed [SUM_W-1:0] off;
    off = SUM_W'(signed'({1'b0, idx})) - SUM_W'(half);
    return sat_q(off <<< shamt);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mbe_apb_regs.sv =====
// ----------------------------------------------------------------------------
// mbe_apb_regs
// APB register slave holding the iteration limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_apb_regs
  import mbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CNT_W-1:0]  iteration_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= ITER_LIMIT_RST;
    end else if (wr_en && (paddr[2] == REG_ITER_LIMIT)) begin
      iteration_limit <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ITER_LIMIT) begin
      prdata = DATA_W'(iteration_limit);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbe_mult_unit.sv =====
// ----------------------------------------------------------------------------
// mbe_mult_unit
// Shared signed Q4.F multiplier with registered full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mult_unit
  import mbe_pkg::*;
(
  input  wire logic clk,
  input  wire q_t   op_a,
  input  wire q_t   op_b,
  output prod_t     prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

`default_nettype wire

// ===== hdl/mbe_iter_engine.sv =====
// ----------------------------------------------------------------------------
// mbe_iter_engine
// Sequencer running z = z^2 + c on one shared multiplier, stepping S_RR, S_II, S_RI, S_UPD.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_iter_engine
  import mbe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [COL_W-1:0] column,
  input  wire logic [ROW_W-1:0] row,
  input  wire logic [CNT_W-1:0] iteration_limit,
  output logic                  busy,
  output mbe_res_t              res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RR   = 3'd1;
  localparam logic [2:0] S_II   = 3'd2;
  localparam logic [2:0] S_RI   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  q_t               cr, ci, zr, zi;
  prod_t            rr, ii, prod;
  q_t               op_a, op_b;

  logic signed [SUM_W-1:0] mag;
  logic signed [SUM_W-1:0] diff;
  logic signed [SUM_W-1:0] twice;
  q_t                      nr, ni;
  logic                    escape;

  mbe_mult_unit u_mult (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  always_comb begin
    case (state)
      S_II: begin
        op_a = zi;
        op_b = zi;
      end
      S_RI: begin
        op_a = zr;
        op_b = zi;
      end
      default: begin
        op_a = zr;
        op_b = zr;
      end
    endcase
  end

  // in S_RI prod holds zi^2; in S_UPD it holds zr*zi
  always_comb begin
    mag    = SUM_W'(rr) + SUM_W'(prod);
    escape = (mag >= FOUR_SQ);
    diff   = SUM_W'(rr) - SUM_W'(ii);
    twice  = SUM_W'(prod) <<< 1;
    nr     = sat_q((diff >>> FRACTION_BITS) + SUM_W'(cr));
    ni     = sat_q((twice >>> FRACTION_BITS) + SUM_W'(ci));
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    res.in_set <= (count == iteration_limit);
    res.iters  <= count;
    if (rst) begin
      state    <= S_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RR;
          end
        end
        S_RR: begin
          if (count >= iteration_limit) begin
            state    <= S_IDLE;
            res.done <= 1'b1;
          end else begin
            state <= S_II;
          end
        end
        S_II: begin
          state <= S_RI;
        end
        S_RI: begin
          if (escape) begin
            state    <= S_IDLE;
            res.done <= 1'b1;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          state <= S_RR;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cr    <= map_axis(MAP_W'(column), COL_HALF, COL_SH);
        ci    <= map_axis(MAP_W'(row), ROW_HALF, ROW_SH);
        zr    <= '0;
        zi    <= '0;
        count <= '0;
      end
      S_II: begin
        rr <= prod;
      end
      S_RI: begin
        ii <= prod;
      end
      S_UPD: begin
        zr    <= nr;
        zi    <= ni;
        count <= count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

  a_iters_bound: assert property (@(posedge clk) disable iff (rst)
    res.done |-> (res.iters <= iteration_limit))
    else $error("iteration count beyond limit");

  a_in_set_count: assert property (@(posedge clk) disable iff (rst)
    (res.done && res.in_set) |-> (res.iters == iteration_limit))
    else $error("in-set flag without full count");

  a_upd_loop: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> (state == S_RR))
    else $error("update not followed by next pass");

endmodule

`default_nettype wire

// ===== hdl/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Mandelbrot escape-time evaluator: one pixel in, escape flag and count out.
// ----------------------------------------------------------------------------
// A run ends when the limit n is reached or when the point escapes after k passes.
// Throughput: one pixel at a time; each pass uses the shared multiplier for
//   three products plus an update step. busy drops as done is strobed.
// The result is held for the single done cycle; the receiver cannot stall.
// Reset: synchronous; the engine goes idle and iteration_limit returns to 20.
`default_nettype none

module mandelbrot_escape_time_core
  import mbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [COL_W-1:0]  column,
  input  wire logic [ROW_W-1:0]  row,
  output logic                   done,
  output logic                   inside_res,
  output logic      [CNT_W-1:0]  iterations_run,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [CNT_W-1:0] iteration_limit;
  mbe_res_t         res;

  mbe_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .iteration_limit (iteration_limit)
  );

  mbe_iter_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .column          (column),
    .row             (row),
    .iteration_limit (iteration_limit),
    .busy            (busy),
    .res             (res)
  );

  assign done           = res.done;
  assign inside_res     = res.in_set;
  assign iterations_run = res.iters;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mandelbrot_escape_time_core. Pixels are sent in
// bursts with random gaps. Each accepted pixel is run through a local
// escape-time predictor, and each done strobe is compared with the oldest
// prediction. The iteration limit is changed over APB between phases, each
// write is read back, and the phases cover the zero, one and full-scale limits.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import mbe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] LIMIT_ADDR  = ADDR_W'(4 * REG_ITER_LIMIT);
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = LIMIT_ADDR + ADDR_W'(4);
  localparam longint Q_HI    = (longint'(8) << FRACTION_BITS) - 1;
  localparam longint Q_LO    = -(longint'(8) << FRACTION_BITS);
  localparam longint ESC_RAD = longint'(4) << (2 * FRACTION_BITS);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] rw;
  } pixel_t;

  typedef struct packed {
    logic             in_set;
    logic [CNT_W-1:0] iters;
  } escape_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [COL_W-1:0]  column = '0;
  logic [ROW_W-1:0]  row = '0;
  logic              done;
  logic              inside_res;
  logic [CNT_W-1:0]  iterations_run;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pixel_t  pixel_queue[$];
  escape_t escape_queue[$];
  logic [CNT_W-1:0] limit_model = ITER_LIMIT_RST;
  int pushed_total = 0;
  int accepted_count = 0;
  int results_count = 0;
  int errors = 0;
  int burst_left = 1;
  int gap_left = 0;
  bit drain_wait = 1'b0;

  mandelbrot_escape_time_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .column(column), .row(row),
    .done(done), .inside_res(inside_res), .iterations_run(iterations_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic q_t clamp_q(input longint v);
    if (v > Q_HI) begin
      return q_t'(Q_HI);
    end else if (v < Q_LO) begin
      return q_t'(Q_LO);
    end
    return q_t'(v);
  endfunction

  // escape-time iteration: z <- z^2 + c, full-width products floored before adding c
  function automatic escape_t predict_escape(input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] rw,
                                             input logic [CNT_W-1:0] lim);
    q_t c_re, c_im, z_re, z_im, nxt_re;
    longint re_sq, im_sq;
    int n;
    bit escaped;
    escape_t r;
    c_re = clamp_q(((longint'(col) - GRID_WIDTH / 2) * (longint'(1) << FRACTION_BITS))
                   / (GRID_WIDTH / 4));
    c_im = clamp_q(((longint'(rw) - GRID_HEIGHT / 2) * (longint'(1) << FRACTION_BITS))
                   / (GRID_HEIGHT / 4));
    z_re = '0;
    z_im = '0;
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < int'(lim)) begin
      re_sq = longint'(z_re) * longint'(z_re);
      im_sq = longint'(z_im) * longint'(z_im);
      if (re_sq + im_sq >= ESC_RAD) begin
        escaped = 1'b1;
      end else begin
        nxt_re = clamp_q(((re_sq - im_sq) >>> FRACTION_BITS) + longint'(c_re));
        z_im = clamp_q(((2 * longint'(z_re) * longint'(z_im)) >>> FRACTION_BITS)
                       + longint'(c_im));
        z_re = nxt_re;
        n++;
      end
    end
    r.in_set = (n == int'(lim));
    r.iters = n[CNT_W-1:0];
    return r;
  endfunction

  // driver: bursts of pixels, random gaps, the odd pause until drained
  always @(posedge clk) begin
    pixel_t px;
    bit took;
    took = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        escape_queue.push_back(predict_escape(column, row, limit_model));
        accepted_count <= accepted_count + 1;
      end
      if (start && busy) begin
        // transfer pending, hold the item
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (drain_wait && accepted_count + int'(took) != results_count) begin
        start <= 1'b0;
      end else if (pixel_queue.size() == 0) begin
        start <= 1'b0;
      end else begin
        px = pixel_queue.pop_front();
        column <= px.col;
        row <= px.rw;
        start <= 1'b1;
        drain_wait = 1'b0;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          drain_wait = ($urandom_range(0, 7) == 0);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    escape_t want;
    if (!rst && done) begin
      results_count <= results_count + 1;
      if (escape_queue.size() == 0) begin
        $display("%0t: result with nothing expected: inside=%0b iterations=%0d",
                 $time, inside_res, iterations_run);
        errors++;
      end else begin
        want = escape_queue.pop_front();
        if (inside_res !== want.in_set) begin
          $display("%0t: inside_res expected %0b actual %0b",
                   $time, want.in_set, inside_res);
          errors++;
        end
        if (iterations_run !== want.iters) begin
          $display("%0t: iterations_run expected %0d actual %0d",
                   $time, want.iters, iterations_run);
          errors++;
        end
      end
    end
  end

  task automatic push_pixel(input int col, input int rw);
    pixel_t px;
    px.col = col[COL_W-1:0];
    px.rw = rw[ROW_W-1:0];
    pixel_queue.push_back(px);
    pushed_total++;
  endtask

  // counters are updated with nonblocking writes, so this sees settled values
  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_count != pushed_total || results_count != accepted_count || busy);
  endtask

  task automatic apb_transfer(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_limit();
    logic [DATA_W-1:0] rd;
    apb_transfer(1'b0, LIMIT_ADDR, '0, rd);
    if (rd !== DATA_W'(limit_model)) begin
      $display("%0t: iteration_limit readback expected %0d actual %0d",
               $time, limit_model, rd);
      errors++;
    end
  endtask

  // upper bits carry noise; only the low byte is kept
  task automatic write_limit(input logic [ADDR_W-1:0] addr, input int lim);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] wd;
    wd = ($urandom() & 32'hFFFF_FF00) | DATA_W'(lim & 8'hFF);
    apb_transfer(1'b1, addr, wd, rd);
    if (addr == LIMIT_ADDR) begin
      limit_model = wd[CNT_W-1:0];
    end
    check_limit();
  endtask

  // mostly the interesting part of the plane, some anywhere
  task automatic push_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        push_pixel($urandom_range(12, 44), $urandom_range(6, 26));
      end else begin
        push_pixel($urandom_range(0, 63), $urandom_range(0, 31));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_limit();

    // corners, origin, real axis ends, the period-2 point, +/- i
    push_pixel(0, 0);
    push_pixel(63, 0);
    push_pixel(0, 31);
    push_pixel(63, 31);
    push_pixel(32, 16);
    push_pixel(0, 16);
    push_pixel(48, 16);
    push_pixel(16, 16);
    push_pixel(32, 24);
    push_pixel(32, 8);
    push_pixel(40, 16);
    push_pixel(31, 15);
    push_pixel(33, 17);
    push_pixel(42, 21);
    push_pixel(21, 10);
    push_pixel(63, 16);
    push_pixel(32, 0);
    push_pixel(32, 31);
    push_pixel(42, 10);
    push_pixel(20, 22);
    wait_idle();

    write_limit(UNUSED_ADDR, 3);
    push_random(60);
    wait_idle();

    write_limit(LIMIT_ADDR, 1);
    push_random(150);
    wait_idle();

    write_limit(LIMIT_ADDR, 255);
    push_random(30);
    wait_idle();

    write_limit(LIMIT_ADDR, 0);
    push_random(60);
    wait_idle();

    repeat (5) begin
      write_limit(LIMIT_ADDR, $urandom_range(2, 64));
      push_random(120);
      wait_idle();
    end

    write_limit(LIMIT_ADDR, 100);
    push_random(80);
    wait_idle();

    // catch any stray strobe after the last result
    repeat (64) @(posedge clk);
    if (errors == 0 && escape_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
